// ===== design/signed_decimal_formatter_top_assert.svh =====
// Assertion macros for the signed decimal formatter.
`ifndef SIGNED_DECIMAL_FORMATTER_TOP_ASSERT_SVH
`define SIGNED_DECIMAL_FORMATTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sdf_pkg.sv =====
// Package for the signed decimal formatter: constants and shared types.
package sdf_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int MAX_DIGITS  = 10;
   localparam int COUNT_W     = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;

   // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;

   // One converted number: sign plus digits, least significant at index 0.
   typedef struct packed {
      logic                                neg;
      logic [COUNT_W-1:0]                  count;
      logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits;
   } digit_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      FRONT_IDLE = 3'b001,
      FRONT_CONV = 3'b010,
      FRONT_HOLD = 3'b100
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE = 2'b01,
      BACK_EMIT = 2'b10
   } back_state_type;

endpackage

// ===== design/signed_decimal_formatter_top.sv =====
// Top level of the signed decimal formatter: front end, queue, back end.
//
// A transaction on the request side is one signed 32-bit req_value, taken at a
// rising edge with start high and busy low. It comes out as a run of ASCII
// characters on rsp_char_code, most significant first: a '-' for negative
// values, then the decimal digits with no leading zeros (zero prints as a
// single '0', the most negative value prints in full). Each character is on
// the rsp_ ports for exactly one cycle with rsp_valid high, and rsp_last marks
// the final one of a number. The receiver cannot stall: it must take every
// character in the cycle it appears. The front end stays busy while it
// splits a number into digits, one digit per cycle through one 32x32
// reciprocal multiplier, and until the queue has room for the result; it
// takes no new number before that. The back end sends one character per
// digit (1..10 digits), plus one for a sign, back to back and picks up the
// next queued number on the cycle the last character leaves. A number
// passes from the front end's registers through the queue into the back
// end's registers, and each character is registered once more onto the
// rsp_ ports. No memory clearing is needed at reset.
module signed_decimal_formatter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_char_code,
   output logic                          rsp_last
);
   import sdf_pkg::*;

   queue_status_type q_status;
   digit_rec_type    push_rec;
   digit_rec_type    head_rec;
   logic             push_valid;
   logic             pop;
   logic             minus_out;
   logic             char_ok;

   // sign, magnitude and digit split, one digit per cycle
   sdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .value      (req_value),
      .busy       (busy),
      .status     (q_status),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   // decouples conversion from character output
   sdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .pop        (pop),
      .head_rec   (head_rec),
      .status     (q_status)
   );

   // character sequencer with registered outputs
   sdf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_rec      (head_rec),
      .status        (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   // character classes seen by the checks below
   assign minus_out = rsp_valid && (rsp_char_code == CHAR_MINUS);
   assign char_ok   = (rsp_char_code == CHAR_MINUS) ||
                      ((rsp_char_code >= CHAR_ZERO) && (rsp_char_code <= CHAR_ZERO + 8'd9));

`include "signed_decimal_formatter_top_assert.svh"

   // a sign never ends a run
   `SDF_ASSERT_NOW(a_minus_not_last, clock, reset, minus_out, !rsp_last, "minus marked last")
   // only a sign or a digit goes out
   `SDF_ASSERT_NOW(a_char_legal, clock, reset, rsp_valid, char_ok, "illegal character code")
   // an accepted transaction makes the front end busy
   `SDF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")
   // queue occupancy is never both full and empty
   `SDF_ASSERT_NOW(a_queue_sane, clock, reset, q_status.full, !q_status.empty, "queue status")

endmodule

// ===== design/sdf_front.sv =====
// Front end: accepts a value, takes sign and magnitude, splits it into digits.
module sdf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sdf_pkg::VALUE_W-1:0]   value,
   output logic                          busy,
   input  sdf_pkg::queue_status_type     status,
   output logic                          push_valid,
   output sdf_pkg::digit_rec_type        push_rec
);
   import sdf_pkg::*;

   front_state_type                     state_ff, state_in;
   logic                                neg_ff;
   logic [VALUE_W-1:0]                  mag_ff;
   logic [COUNT_W-1:0]                  count_ff;
   logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_ff;

   logic [2*VALUE_W-1:0] prod;
   logic [VALUE_W-1:0]   quot;
   logic [DIGIT_W-1:0]   digit;

   // divide by ten by reciprocal; remainder fits in the low nibble
   always_comb begin
      prod  = {{VALUE_W{1'b0}}, mag_ff} * {{VALUE_W{1'b0}}, RECIP_TEN};
      quot  = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
      digit = mag_ff[DIGIT_W-1:0] - DIGIT_W'(quot[DIGIT_W-1:0] * RADIX);
   end

   assign busy       = (state_ff != FRONT_IDLE);
   assign push_valid = (state_ff == FRONT_HOLD) && !status.full;
   assign push_rec   = '{neg: neg_ff, count: count_ff, digits: digits_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: if (start) state_in = FRONT_CONV;
         FRONT_CONV: if (quot == '0) state_in = FRONT_HOLD;
         FRONT_HOLD: if (!status.full) state_in = FRONT_IDLE;
         default:    state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FRONT_IDLE && start) begin
         neg_ff   <= value[VALUE_W-1];
         mag_ff   <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
         count_ff <= '0;
      end else if (state_ff == FRONT_CONV) begin
         digits_ff[count_ff] <= digit;
         count_ff            <= count_ff + COUNT_W'(1);
         mag_ff              <= quot;
      end
   end

endmodule

// ===== design/sdf_queue.sv =====
// Short FIFO of converted numbers between front and back end.
module sdf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  sdf_pkg::digit_rec_type        push_rec,
   input  logic                          pop,
   output sdf_pkg::digit_rec_type        head_rec,
   output sdf_pkg::queue_status_type     status
);
   import sdf_pkg::*;

   digit_rec_type       entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic                do_push, do_pop;

   assign status.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_rec     = entries_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (do_push && !do_pop)      fill_ff <= fill_ff + FILL_W'(1);
         else if (do_pop && !do_push) fill_ff <= fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

// ===== design/sdf_back.sv =====
// Back end: walks a converted number and emits one character per cycle.
module sdf_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sdf_pkg::digit_rec_type        head_rec,
   input  sdf_pkg::queue_status_type     status,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [sdf_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic                          rsp_last
);
   import sdf_pkg::*;

   back_state_type                      state_ff;
   logic                                neg_ff;
   logic [COUNT_W-1:0]                  idx_ff;
   logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  digits_ff;
   logic                                rsp_valid_ff;
   logic [CHAR_W-1:0]                   rsp_char_code_ff;
   logic                                rsp_last_ff;

   logic              emit;
   logic              emit_last;
   logic [CHAR_W-1:0] emit_char;

   always_comb begin
      emit      = (state_ff == BACK_EMIT);
      emit_last = !neg_ff && (idx_ff == '0);
      emit_char = neg_ff ? CHAR_MINUS
                         : CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_ff[idx_ff]};
      // reload on the cycle the last character goes out
      pop       = !status.empty && (!emit || emit_last);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_last      = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit;
         unique case (state_ff)
            BACK_IDLE: if (pop) state_ff <= BACK_EMIT;
            BACK_EMIT: if (emit_last && !pop) state_ff <= BACK_IDLE;
            default:   state_ff <= BACK_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_char_code_ff <= emit_char;
         rsp_last_ff      <= emit_last;
      end
      if (pop) begin
         neg_ff    <= head_rec.neg;
         idx_ff    <= head_rec.count - COUNT_W'(1);
         digits_ff <= head_rec.digits;
      end else if (emit) begin
         if (neg_ff) neg_ff <= 1'b0;
         else        idx_ff <= idx_ff - COUNT_W'(1);
      end
   end

endmodule
